// ----- rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_AT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition in one cycle implies a condition in the next one.
`define ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) else $error(msg);

`endif

// ----- rtl/tbag_pkg.sv -----
// Types, constants and the reciprocal table of the texture block address generator.
package tbag_pkg;

  localparam int MAX_DIM    = 16384;
  localparam int MAX_MIPS   = 15;
  localparam int MAX_LAYERS = 2048;

  localparam int LAYER_W = 11;
  localparam int MIP_W   = 4;
  localparam int SLICE_W = 11;
  localparam int TEX_W   = 14;
  localparam int DIM_W   = 15;
  localparam int CNT_W   = 12;
  localparam int OFF_W   = 48;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 80;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // shared multiplier: narrow operand a, wide operand b
  localparam int MUL_A_W = 15;
  localparam int MUL_B_W = 36;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // floor(x / d) == (x * recip(d)) >> RECIP_SHIFT for x < 2^15, d <= 15
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_WIDTH  = 3'd0,
    REG_BLOCK_HEIGHT = 3'd1,
    REG_BLOCK_BYTES  = 3'd2,
    REG_BASE_WIDTH   = 3'd3,
    REG_BASE_HEIGHT  = 3'd4,
    REG_SLICE_COUNT  = 3'd5,
    REG_MIP_COUNT    = 3'd6,
    REG_LAYER_COUNT  = 3'd7
  } tbag_reg_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK,
    S_DX,
    S_DY,
    S_XY,
    S_XB,
    S_XS,
    S_QX,
    S_QY,
    S_PIT,
    S_SSZ,
    S_SLC,
    S_ROW,
    S_COL,
    S_LLO,
    S_LHI,
    S_ADDH,
    S_DONE
  } tbag_state_e;

  // ceil(2^19 / d); zero acts as one
  function automatic logic [RECIP_W-1:0] recip_f(input logic [3:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      4'd2:    r = 20'd262144;
      4'd3:    r = 20'd174763;
      4'd4:    r = 20'd131072;
      4'd5:    r = 20'd104858;
      4'd6:    r = 20'd87382;
      4'd7:    r = 20'd74899;
      4'd8:    r = 20'd65536;
      4'd9:    r = 20'd58255;
      4'd10:   r = 20'd52429;
      4'd11:   r = 20'd47663;
      4'd12:   r = 20'd43691;
      4'd13:   r = 20'd40330;
      4'd14:   r = 20'd37450;
      4'd15:   r = 20'd34953;
      default: r = 20'd524288;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/texture_block_address_generator.sv -----
// Texture block address generator: block byte offset in a layered mipmapped texture.
// An in-range request is checked, then takes five multiplier products per mip level in use,
//   nine for the offset terms and one last add; an out-of-range one goes from the check
//   straight to the result. A new beat is taken only after the result is loaded for output,
//   and all products go through the shared 15x36 multiplier.
// Reset (rst_ni low, async) returns to idle, empties the output and loads register defaults.
module texture_block_address_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [tbag_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tbag_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // layer[10:0], mip[14:11], slice[25:15], texel_x[39:26], texel_y[53:40], zero pad
  input  logic [tbag_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // byte_offset[47:0], mip_width[62:48], mip_height[77:63], zero pad
  output logic [tbag_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status[0]
  output logic [0:0]                     m_axis_tuser
);
  import tbag_pkg::*;

  // configuration registers
  logic [3:0]       bw_q, bh_q, mips_q;
  logic [4:0]       bb_q;
  logic [DIM_W-1:0] basew_q, baseh_q;
  logic [CNT_W-1:0] slices_q, layers_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q     <= 4'd1;
      bh_q     <= 4'd1;
      bb_q     <= 5'd4;
      basew_q  <= 15'd1;
      baseh_q  <= 15'd1;
      slices_q <= 12'd1;
      mips_q   <= 4'd1;
      layers_q <= 12'd1;
    end else if (cfg_we_i) begin
      unique case (tbag_reg_e'(cfg_index_i))
        REG_BLOCK_WIDTH:  bw_q     <= cfg_wdata_i[3:0];
        REG_BLOCK_HEIGHT: bh_q     <= cfg_wdata_i[3:0];
        REG_BLOCK_BYTES:  bb_q     <= cfg_wdata_i[4:0];
        REG_BASE_WIDTH:   basew_q  <= cfg_wdata_i[DIM_W-1:0];
        REG_BASE_HEIGHT:  baseh_q  <= cfg_wdata_i[DIM_W-1:0];
        REG_SLICE_COUNT:  slices_q <= cfg_wdata_i[CNT_W-1:0];
        REG_MIP_COUNT:    mips_q   <= cfg_wdata_i[3:0];
        REG_LAYER_COUNT:  layers_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective register values: zero sizes act as one, oversized base sizes and mip and layer counts clamp
  logic [3:0]       bw_eff, bh_eff, mips_eff;
  logic [4:0]       bb_eff;
  logic [DIM_W-1:0] basew_eff, baseh_eff;
  logic [CNT_W-1:0] layers_eff;

  always_comb begin
    bw_eff = (bw_q == 4'd0) ? 4'd1 : bw_q;
    bh_eff = (bh_q == 4'd0) ? 4'd1 : bh_q;
    bb_eff = (bb_q == 5'd0) ? 5'd1 : bb_q;
    if (basew_q == '0)                basew_eff = DIM_W'(1);
    else if (basew_q > DIM_W'(MAX_DIM)) basew_eff = DIM_W'(MAX_DIM);
    else                              basew_eff = basew_q;
    if (baseh_q == '0)                baseh_eff = DIM_W'(1);
    else if (baseh_q > DIM_W'(MAX_DIM)) baseh_eff = DIM_W'(MAX_DIM);
    else                              baseh_eff = baseh_q;
    mips_eff   = (mips_q > MIP_W'(MAX_MIPS)) ? MIP_W'(MAX_MIPS) : mips_q;
    layers_eff = (layers_q > CNT_W'(MAX_LAYERS)) ? CNT_W'(MAX_LAYERS) : layers_q;
  end

  // dimensions of the requested mip, taken straight from the incoming beat
  logic [MIP_W-1:0] in_mip;
  logic [DIM_W-1:0] shw, shh, lvl_w, lvl_h;

  assign in_mip = s_axis_tdata[14:11];
  assign shw    = basew_eff >> in_mip;
  assign shh    = baseh_eff >> in_mip;
  assign lvl_w  = (shw == '0) ? DIM_W'(1) : shw;
  assign lvl_h  = (shh == '0) ? DIM_W'(1) : shh;

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod_q;

  tbag_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod_q)
  );

  // sequencer state
  tbag_state_e state_q, state_d;
  logic        acc_pend_q, acc_pend_d;   // product of the last mip pass still to add
  logic        out_valid_q;
  logic        out_load;

  // request and datapath registers
  logic [LAYER_W-1:0] layer_q, layer_d;
  logic [MIP_W-1:0]   mip_q, mip_d;
  logic [SLICE_W-1:0] slice_q, slice_d;
  logic [TEX_W-1:0]   tx_q, tx_d, ty_q, ty_d;
  logic [DIM_W-1:0]   mw_q, mw_d, mh_q, mh_d;
  logic [MIP_W-1:0]   m_q, m_d;
  logic [DIM_W-1:0]   w_q, w_d, h_q, h_d;
  logic [DIM_W-1:0]   bx_q, bx_d, bx_sel_q, bx_sel_d, by_sel_q, by_sel_d;
  logic [TEX_W-1:0]   qx_q, qx_d, qy_q, qy_d;
  logic [18:0]        pitch_q, pitch_d;
  logic [OFF_W-1:0]   ls_q, ls_d, off_q, off_d;
  logic               to_off_q, to_off_d, ok_q, ok_d;
  logic               req_ok;
  logic [DIM_W-1:0]   quo, w_half, h_half;

  // out-of-range check on the latched request
  assign req_ok = ({1'b0, layer_q} < layers_eff) && (mip_q < mips_eff) &&
                  ({1'b0, slice_q} < slices_q) &&
                  ({1'b0, tx_q} < mw_q) && ({1'b0, ty_q} < mh_q);

  // quotient of the previous reciprocal multiply
  assign quo    = prod_q[RECIP_SHIFT+DIM_W-1:RECIP_SHIFT];
  assign w_half = ((w_q >> 1) == '0) ? DIM_W'(1) : (w_q >> 1);
  assign h_half = ((h_q >> 1) == '0) ? DIM_W'(1) : (h_q >> 1);

  always_comb begin
    state_d    = state_q;
    acc_pend_d = 1'b0;
    out_load   = 1'b0;
    layer_d    = layer_q;
    mip_d      = mip_q;
    slice_d    = slice_q;
    tx_d       = tx_q;
    ty_d       = ty_q;
    mw_d       = mw_q;
    mh_d       = mh_q;
    m_d        = m_q;
    w_d        = w_q;
    h_d        = h_q;
    bx_d       = bx_q;
    bx_sel_d   = bx_sel_q;
    by_sel_d   = by_sel_q;
    qx_d       = qx_q;
    qy_d       = qy_q;
    pitch_d    = pitch_q;
    ls_d       = ls_q;
    off_d      = off_q;
    to_off_d   = to_off_q;
    ok_d       = ok_q;
    mul_a      = '0;
    mul_b      = '0;

    // mip size from the last pass: into layer size, and into offset below the requested mip
    if (acc_pend_q) begin
      ls_d = ls_q + prod_q[OFF_W-1:0];
      if (to_off_q) off_d = off_q + prod_q[OFF_W-1:0];
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          layer_d = s_axis_tdata[10:0];
          mip_d   = in_mip;
          slice_d = s_axis_tdata[25:15];
          tx_d    = s_axis_tdata[39:26];
          ty_d    = s_axis_tdata[53:40];
          mw_d    = lvl_w;
          mh_d    = lvl_h;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        ok_d  = req_ok;
        off_d = '0;
        ls_d  = '0;
        m_d   = '0;
        w_d   = basew_eff;
        h_d   = baseh_eff;
        state_d = req_ok ? S_DX : S_DONE;
      end
      // ceil(w / bw) as floor((w + bw - 1) / bw)
      S_DX: begin
        mul_a   = w_q + DIM_W'(bw_eff) - DIM_W'(1);
        mul_b   = MUL_B_W'(recip_f(bw_eff));
        state_d = S_DY;
      end
      S_DY: begin
        bx_d    = quo;
        mul_a   = h_q + DIM_W'(bh_eff) - DIM_W'(1);
        mul_b   = MUL_B_W'(recip_f(bh_eff));
        state_d = S_XY;
      end
      S_XY: begin
        if (m_q == mip_q) begin
          bx_sel_d = bx_q;
          by_sel_d = quo;
        end
        mul_a   = bx_q;
        mul_b   = MUL_B_W'(quo);
        state_d = S_XB;
      end
      S_XB: begin
        mul_a   = MUL_A_W'(bb_eff);
        mul_b   = prod_q[MUL_B_W-1:0];
        state_d = S_XS;
      end
      S_XS: begin
        mul_a      = MUL_A_W'(slices_q);
        mul_b      = prod_q[MUL_B_W-1:0];
        acc_pend_d = 1'b1;
        to_off_d   = (m_q < mip_q);
        m_d        = m_q + MIP_W'(1);
        w_d        = w_half;
        h_d        = h_half;
        state_d    = (m_q == MIP_W'(mips_eff - MIP_W'(1))) ? S_QX : S_DX;
      end
      // block coordinates, floor division
      S_QX: begin
        mul_a   = MUL_A_W'(tx_q);
        mul_b   = MUL_B_W'(recip_f(bw_eff));
        state_d = S_QY;
      end
      S_QY: begin
        qx_d    = quo[TEX_W-1:0];
        mul_a   = MUL_A_W'(ty_q);
        mul_b   = MUL_B_W'(recip_f(bh_eff));
        state_d = S_PIT;
      end
      S_PIT: begin
        qy_d    = quo[TEX_W-1:0];
        mul_a   = MUL_A_W'(bb_eff);
        mul_b   = MUL_B_W'(bx_sel_q);
        state_d = S_SSZ;
      end
      S_SSZ: begin
        pitch_d = prod_q[18:0];
        mul_a   = by_sel_q;
        mul_b   = MUL_B_W'(prod_q[18:0]);
        state_d = S_SLC;
      end
      S_SLC: begin
        mul_a   = MUL_A_W'(slice_q);
        mul_b   = prod_q[MUL_B_W-1:0];
        state_d = S_ROW;
      end
      S_ROW: begin
        off_d   = off_q + prod_q[OFF_W-1:0];
        mul_a   = MUL_A_W'(qy_q);
        mul_b   = MUL_B_W'(pitch_q);
        state_d = S_COL;
      end
      S_COL: begin
        off_d   = off_q + prod_q[OFF_W-1:0];
        mul_a   = MUL_A_W'(qx_q);
        mul_b   = MUL_B_W'(bb_eff);
        state_d = S_LLO;
      end
      // layer * layer size in two 24-bit halves, wrapping at 48 bits
      S_LLO: begin
        off_d   = off_q + prod_q[OFF_W-1:0];
        mul_a   = MUL_A_W'(layer_q);
        mul_b   = MUL_B_W'(ls_q[23:0]);
        state_d = S_LHI;
      end
      S_LHI: begin
        off_d   = off_q + prod_q[OFF_W-1:0];
        mul_a   = MUL_A_W'(layer_q);
        mul_b   = MUL_B_W'(ls_q[47:24]);
        state_d = S_ADDH;
      end
      S_ADDH: begin
        off_d   = off_q + {prod_q[23:0], 24'd0};
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      acc_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      acc_pend_q <= acc_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    layer_q  <= layer_d;
    mip_q    <= mip_d;
    slice_q  <= slice_d;
    tx_q     <= tx_d;
    ty_q     <= ty_d;
    mw_q     <= mw_d;
    mh_q     <= mh_d;
    m_q      <= m_d;
    w_q      <= w_d;
    h_q      <= h_d;
    bx_q     <= bx_d;
    bx_sel_q <= bx_sel_d;
    by_sel_q <= by_sel_d;
    qx_q     <= qx_d;
    qy_q     <= qy_d;
    pitch_q  <= pitch_d;
    ls_q     <= ls_d;
    off_q    <= off_d;
    to_off_q <= to_off_d;
    ok_q     <= ok_d;
  end

  // output register: holds a finished beat while the next request runs
  logic [OFF_W-1:0] out_off_q;
  logic [DIM_W-1:0] out_mw_q, out_mh_q;
  logic             out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_off_q <= off_q;
      out_mw_q  <= mw_q;
      out_mh_q  <= mh_q;
      out_st_q  <= ~ok_q;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_mh_q, out_mw_q, out_off_q};
  assign m_axis_tuser  = out_st_q;

endmodule

// ----- rtl/tbag_mul.sv -----
// Shared multiplier of the address sequencer, product registered.
module tbag_mul (
  input  logic                        clk_i,
  input  logic [tbag_pkg::MUL_A_W-1:0] a_i,
  input  logic [tbag_pkg::MUL_B_W-1:0] b_i,
  output logic [tbag_pkg::MUL_P_W-1:0] p_o
);
  import tbag_pkg::*;

  logic [MUL_P_W-1:0] p_d;
  logic [MUL_P_W-1:0] p_q;

  assign p_d = MUL_P_W'(a_i) * MUL_P_W'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ----- rtl/tbag_checker.sv -----
// Port-level assertions of the texture block address generator, bound to the top level.
`include "assert_macros.svh"

module tbag_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tbag_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]                     m_axis_tuser
);
  import tbag_pkg::*;

  // error beats carry a zero offset
  `ASSERT_AT_CLK(a_err_zero_off, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[47:0] == 48'd0, "error result with nonzero offset")

  // mip dimensions stay within one and the largest base size
  `ASSERT_AT_CLK(a_dim_range, m_axis_tvalid |-> m_axis_tdata[62:48] != 15'd0 && m_axis_tdata[77:63] != 15'd0 && m_axis_tdata[62:48] <= 15'(MAX_DIM) && m_axis_tdata[77:63] <= 15'(MAX_DIM), "mip dimension out of range")

  // one request at a time: busy right after taking a beat
  `ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind texture_block_address_generator tbag_checker u_tbag_checker (.*);

// ----- tb/texture_offset_checker.sv -----
// Checker for the texture block address generator: predicts each result beat and compares it.
`timescale 1ns / 100ps
module texture_offset_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tbag_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tbag_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  // layer, mip, slice, texel_x, texel_y, zero pad
  input  logic [tbag_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // byte_offset, mip_width, mip_height, zero pad
  input  logic [tbag_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status
  input  logic [0:0]                      m_axis_tuser,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              results_o,
  output int                              out_of_range_o
);
  import tbag_pkg::*;

  typedef logic [63:0] wide_t;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [DIM_W-1:0] mip_w;
    logic [DIM_W-1:0] mip_h;
    logic             status;
  } addr_result_t;

  // shadow copy of the register file, at register widths
  logic [3:0]  blk_w_q     = 4'd1;
  logic [3:0]  blk_h_q     = 4'd1;
  logic [4:0]  blk_bytes_q = 5'd4;
  logic [14:0] base_w_q    = 15'd1;
  logic [14:0] base_h_q    = 15'd1;
  logic [11:0] slices_q    = 12'd1;
  logic [3:0]  mips_q      = 4'd1;
  logic [11:0] layers_q    = 12'd1;

  addr_result_t pending_offsets[$];
  addr_result_t got_beat;
  addr_result_t want_beat;
  int           fails = 0;
  int           results = 0;
  int           flagged = 0;

  function automatic wide_t texels_at_level(wide_t base, wide_t lvl);
    wide_t d;
    d = base >> lvl;
    return (d == 0) ? 64'd1 : d;
  endfunction

  function automatic wide_t blocks_across(wide_t texels, wide_t bsize);
    return (texels + bsize - 1) / bsize;
  endfunction

  function automatic addr_result_t predict_block_offset(logic [IN_DATA_W-1:0] beat);
    addr_result_t r;
    wide_t layer, mip, slc, tx, ty;
    wide_t bw, bh, bb, base_w, base_h, slices, mips, layers;
    wide_t mw, mh, layer_size, mip_offset, lvl_size, pitch, slice_size, total;
    logic  ok;
    layer = beat[10:0];
    mip   = beat[14:11];
    slc   = beat[25:15];
    tx    = beat[39:26];
    ty    = beat[53:40];
    // zero sizes act as one, oversized base, mip and layer counts clamp to the build limits
    bw     = (blk_w_q == 0) ? 64'd1 : 64'(blk_w_q);
    bh     = (blk_h_q == 0) ? 64'd1 : 64'(blk_h_q);
    bb     = (blk_bytes_q == 0) ? 64'd1 : 64'(blk_bytes_q);
    base_w = (base_w_q == 0) ? 64'd1 : 64'(base_w_q);
    base_h = (base_h_q == 0) ? 64'd1 : 64'(base_h_q);
    if (base_w > MAX_DIM) base_w = MAX_DIM;
    if (base_h > MAX_DIM) base_h = MAX_DIM;
    slices = slices_q;
    mips   = (mips_q > MAX_MIPS) ? 64'(MAX_MIPS) : 64'(mips_q);
    layers = (layers_q > MAX_LAYERS) ? 64'(MAX_LAYERS) : 64'(layers_q);

    mw = texels_at_level(base_w, mip);
    mh = texels_at_level(base_h, mip);
    ok = (layer < layers) && (mip < mips) && (slc < slices) && (tx < mw) && (ty < mh);
    total = 0;
    if (ok) begin
      layer_size = 0;
      mip_offset = 0;
      for (wide_t m = 0; m < mips; m++) begin
        lvl_size = blocks_across(texels_at_level(base_w, m), bw)
                 * blocks_across(texels_at_level(base_h, m), bh) * bb * slices;
        if (m < mip) mip_offset += lvl_size;
        layer_size += lvl_size;
      end
      pitch      = blocks_across(mw, bw) * bb;
      slice_size = pitch * blocks_across(mh, bh);
      // block coordinate is floor(texel / block size)
      total = layer * layer_size + mip_offset + slc * slice_size
            + (ty / bh) * pitch + (tx / bw) * bb;
    end
    r.offset = total[OFF_W-1:0];
    r.mip_w  = mw[DIM_W-1:0];
    r.mip_h  = mh[DIM_W-1:0];
    r.status = !ok;
    return r;
  endfunction

  task automatic check_field(string name, wide_t want, wide_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_w_q     <= 4'd1;
      blk_h_q     <= 4'd1;
      blk_bytes_q <= 5'd4;
      base_w_q    <= 15'd1;
      base_h_q    <= 15'd1;
      slices_q    <= 12'd1;
      mips_q      <= 4'd1;
      layers_q    <= 12'd1;
      pending_offsets.delete();
      pending_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_BLOCK_WIDTH:  blk_w_q     <= cfg_wdata_i[3:0];
          REG_BLOCK_HEIGHT: blk_h_q     <= cfg_wdata_i[3:0];
          REG_BLOCK_BYTES:  blk_bytes_q <= cfg_wdata_i[4:0];
          REG_BASE_WIDTH:   base_w_q    <= cfg_wdata_i[14:0];
          REG_BASE_HEIGHT:  base_h_q    <= cfg_wdata_i[14:0];
          REG_SLICE_COUNT:  slices_q    <= cfg_wdata_i[11:0];
          REG_MIP_COUNT:    mips_q      <= cfg_wdata_i[3:0];
          REG_LAYER_COUNT:  layers_q    <= cfg_wdata_i[11:0];
          default: ;
        endcase
      end
      // retire before queuing, so a result and a new request in one cycle line up
      if (m_axis_tvalid && m_axis_tready) begin
        got_beat = {m_axis_tdata[47:0], m_axis_tdata[62:48], m_axis_tdata[77:63],
                    m_axis_tuser[0]};
        results++;
        if (pending_offsets.size() == 0) begin
          $display("%0t: result beat with no request outstanding: expected none, got %h",
                   $time, got_beat);
          fails++;
        end else begin
          want_beat = pending_offsets.pop_front();
          check_field("byte_offset", want_beat.offset, got_beat.offset);
          check_field("mip_width", want_beat.mip_w, got_beat.mip_w);
          check_field("mip_height", want_beat.mip_h, got_beat.mip_h);
          check_field("status", want_beat.status, got_beat.status);
          if (want_beat.status) flagged++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_offsets.push_back(predict_block_offset(s_axis_tdata));
      pending_o <= pending_offsets.size();
    end
    fail_count_o   <= fails;
    results_o      <= results;
    out_of_range_o <= flagged;
  end

endmodule

// ----- tb/texture_block_address_generator_tb.sv -----
// Testbench top for the texture block address generator: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module texture_block_address_generator_tb;
  import tbag_pkg::*;

  // One register setting, fields at register widths.
  typedef struct packed {
    logic [3:0]  blk_w;
    logic [3:0]  blk_h;
    logic [4:0]  blk_bytes;
    logic [14:0] base_w;
    logic [14:0] base_h;
    logic [11:0] slices;
    logic [3:0]  mips;
    logic [11:0] layers;
  } tex_setting_t;

  // Receiver back-pressure styles, switched at the end of each random-length segment.
  typedef enum logic [1:0] {
    RX_STREAM,  // always ready
    RX_SPARSE,  // short random stalls
    RX_CHOKED   // mostly stalled
  } rx_mode_e;

  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 120;
  // wait at the end past the longest in-range request, one with fifteen mip levels
  localparam int TAIL_CYCLES     = 120;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  int fail_count;
  int pending;
  int results_seen;
  int flagged_seen;
  int requests_sent    = 0;
  int settings_applied = 0;

  tex_setting_t cur_setting;

  texture_block_address_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  texture_offset_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results_seen),
    .out_of_range_o (flagged_seen)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: segments of random length, each with its own stall style.
  int       rx_seg_left = 0;
  rx_mode_e rx_mode     = RX_STREAM;

  always @(posedge clk_i) begin
    if (rx_seg_left == 0) begin
      rx_seg_left <= $urandom_range(40, 300);
      rx_mode     <= rx_mode_e'($urandom_range(0, 2));
    end else begin
      rx_seg_left <= rx_seg_left - 1;
    end
    case (rx_mode)
      RX_STREAM: m_axis_tready <= 1'b1;
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default:   m_axis_tready <= ($urandom_range(0, 9) > 6);
    endcase
  end

  // Hard stop; a correct run needs a small fraction of this.
  initial begin
    #10_000_000;
    $display("Timeout: %0d results still outstanding", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [IN_DATA_W-1:0] pack_req(int unsigned layer, int unsigned mip,
                                                    int unsigned slc, int unsigned tx,
                                                    int unsigned ty);
    return {2'b00, 14'(ty), 14'(tx), 11'(slc), 4'(mip), 11'(layer)};
  endfunction

  function automatic tex_setting_t mk_setting(int unsigned bw, int unsigned bh,
                                              int unsigned bb, int unsigned base_w,
                                              int unsigned base_h, int unsigned slices,
                                              int unsigned mips, int unsigned layers);
    tex_setting_t s;
    s.blk_w     = 4'(bw);
    s.blk_h     = 4'(bh);
    s.blk_bytes = 5'(bb);
    s.base_w    = 15'(base_w);
    s.base_h    = 15'(base_h);
    s.slices    = 12'(slices);
    s.mips      = 4'(mips);
    s.layers    = 12'(layers);
    return s;
  endfunction

  // Mostly legal settings; a quarter take raw register values (zeros, oversize).
  function automatic tex_setting_t random_setting();
    tex_setting_t s;
    if ($urandom_range(0, 3) == 0) begin
      s = mk_setting($urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom);
    end else begin
      s = mk_setting($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 16),
                     $urandom_range(0, 1) ? $urandom_range(1, MAX_DIM)
                                          : (1 << $urandom_range(0, 14)),
                     $urandom_range(0, 1) ? $urandom_range(1, MAX_DIM)
                                          : (1 << $urandom_range(0, 14)),
                     ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2048)
                                                 : $urandom_range(1, 6),
                     $urandom_range(1, MAX_MIPS),
                     ($urandom_range(0, 2) == 0) ? $urandom_range(1, MAX_LAYERS)
                                                 : $urandom_range(1, 6));
    end
    return s;
  endfunction

  // Mip dimension as the block sees it: base clamped to 1..MAX_DIM, then shifted.
  function automatic int unsigned tex_level(int unsigned base, int unsigned lvl);
    int unsigned b;
    b = (base == 0) ? 1 : ((base > MAX_DIM) ? MAX_DIM : base);
    b = b >> lvl;
    return (b == 0) ? 1 : b;
  endfunction

  // Index below n, leaning on both ends of the range.
  function automatic int unsigned pick_below(int unsigned n);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return n - 1;
      default: return $urandom_range(0, n - 1);
    endcase
  endfunction

  // 70% in-range requests, 20% with one field pushed to its limit, 10% raw noise.
  function automatic logic [IN_DATA_W-1:0] make_request(tex_setting_t s);
    int unsigned lay_n, mip_n, sl_n, layer, mip, slc, tx, ty, mw, mh, roll;
    lay_n = (s.layers > MAX_LAYERS) ? MAX_LAYERS : s.layers;
    mip_n = s.mips;
    sl_n  = s.slices;
    roll  = $urandom_range(0, 9);
    if (roll == 9 || lay_n == 0 || mip_n == 0 || sl_n == 0)
      return pack_req($urandom, $urandom, $urandom, $urandom, $urandom);
    layer = pick_below(lay_n);
    mip   = pick_below(mip_n);
    slc   = pick_below(sl_n);
    mw    = tex_level(s.base_w, mip);
    mh    = tex_level(s.base_h, mip);
    tx    = pick_below(mw);
    ty    = pick_below(mh);
    if (roll >= 7) begin
      case ($urandom_range(0, 4))
        0:       layer = lay_n;
        1:       mip   = mip_n;
        2:       slc   = sl_n;
        3:       tx    = mw;
        default: ty    = mh;
      endcase
    end
    return pack_req(layer, mip, slc, tx, ty);
  endfunction

  // Present one request beat and hold it until taken. Leaves tvalid high so that a
  // following beat in the same burst goes out with no bubble.
  task automatic send_req(logic [IN_DATA_W-1:0] beat);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    requests_sent++;
  endtask

  // Every request yields a result, so an empty scoreboard means the block is idle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic drive_reg(tbag_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // Write all eight registers back to back; enable drops only after the last one.
  task automatic program_regs(tex_setting_t s);
    drive_reg(REG_BLOCK_WIDTH, CFG_DATA_W'(s.blk_w));
    drive_reg(REG_BLOCK_HEIGHT, CFG_DATA_W'(s.blk_h));
    drive_reg(REG_BLOCK_BYTES, CFG_DATA_W'(s.blk_bytes));
    drive_reg(REG_BASE_WIDTH, s.base_w);
    drive_reg(REG_BASE_HEIGHT, s.base_h);
    drive_reg(REG_SLICE_COUNT, CFG_DATA_W'(s.slices));
    drive_reg(REG_MIP_COUNT, CFG_DATA_W'(s.mips));
    drive_reg(REG_LAYER_COUNT, CFG_DATA_W'(s.layers));
    cfg_we_i    <= 1'b0;
    cur_setting  = s;
    settings_applied++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int burst_left;
    int gap;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: 1x1 texture, one mip, one slice, one layer, 4-byte blocks.
    // Only the all-zero request is in range; layer, mip, slice or x bumped by one is rejected.
    cur_setting = mk_setting(1, 1, 4, 1, 1, 1, 1, 1);
    settings_applied++;
    send_req(pack_req(0, 0, 0, 0, 0));
    send_req(pack_req(1, 0, 0, 0, 0));
    send_req(pack_req(0, 1, 0, 0, 0));
    send_req(pack_req(0, 0, 1, 0, 0));
    send_req(pack_req(0, 0, 0, 1, 0));
    send_req(pack_req(2047, 15, 2047, 16383, 16383));
    drain_results();

    // Largest legal texture: far corners, deepest mip, last layer.
    program_regs(mk_setting(12, 12, 16, MAX_DIM, MAX_DIM, 2048, MAX_MIPS, MAX_LAYERS));
    send_req(pack_req(0, 0, 0, 0, 0));
    send_req(pack_req(2047, 14, 2047, 0, 0));
    send_req(pack_req(2047, 0, 2047, 16383, 16383));
    send_req(pack_req(5, 3, 100, 2047, 2047));
    send_req(pack_req(5, 3, 100, 2048, 0));     // x one past the mip edge
    send_req(pack_req(0, 15, 0, 0, 0));         // mip index beyond mip count
    send_req(pack_req(1, 14, 0, 0, 1));         // y past a 1x1 mip
    drain_results();

    // All registers zero: counts of zero reject every request.
    program_regs(mk_setting(0, 0, 0, 0, 0, 0, 0, 0));
    send_req(pack_req(0, 0, 0, 0, 0));
    send_req(pack_req(3, 2, 1, 0, 0));
    drain_results();

    // Zero block sizes and zero base act as one; counts are nonzero.
    program_regs(mk_setting(0, 0, 0, 0, 0, 4, 3, 5));
    send_req(pack_req(4, 2, 3, 0, 0));
    send_req(pack_req(4, 2, 3, 1, 0));
    drain_results();

    // Oversized registers: base clamps to MAX_DIM, layer count to MAX_LAYERS,
    // block sizes beyond the format range are used as written.
    program_regs(mk_setting(15, 13, 31, 32767, 20000, 4095, 15, 4095));
    send_req(pack_req(2047, 14, 0, 0, 0));
    send_req(pack_req(2047, 0, 2047, 16383, 16383));
    send_req(pack_req(1000, 7, 1234, 127, 127));
    send_req(pack_req(3, 2, 5, 4095, 4096));    // y at the mip height
    drain_results();

    // Odd block sizes: floor division of the texel coordinate matters here.
    program_regs(mk_setting(3, 5, 7, 100, 37, 3, 6, 9));
    send_req(pack_req(8, 5, 2, 99, 36));
    send_req(pack_req(8, 5, 2, 2, 1));
    send_req(pack_req(0, 5, 0, 1, 0));
    drain_results();

    // Random part: a fresh register setting per phase, requests sent in bursts with
    // random gaps (sometimes none) so bubbles land at every point of a calculation.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0)
        program_regs(mk_setting(12, 12, 16, MAX_DIM, MAX_DIM, 2048, MAX_MIPS, MAX_LAYERS));
      else
        program_regs(random_setting());
      burst_left = 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
        send_req(make_request(cur_setting));
        burst_left--;
      end
      drain_results();
    end

    // Let any stray result beat show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d register settings with %0d request beats; %0d results checked",
             settings_applied, requests_sent, results_seen);
    $display("Out-of-range results: %0d, field mismatches: %0d", flagged_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tbag_pkg.sv
rtl/tbag_mul.sv
rtl/texture_block_address_generator.sv
rtl/tbag_checker.sv
tb/texture_offset_checker.sv
tb/texture_block_address_generator_tb.sv
